### rtl/afm_pkg.sv
// afm_pkg: shared types, codes and constants of the flaperon mixer
// used by afm_mix, airplane_flaperon_mixer_core and afm_checker; no dependencies
`default_nettype none

package afm_pkg;

   localparam int ServoW   = 12;   // servo pulse and endpoint width
   localparam int CmdW     = 12;   // stick command width
   localparam int PidW     = 13;   // pid correction width
   localparam int FlapW    = 13;   // slewed flap value and its error
   localparam int MixW     = 16;   // wide mixing width, no wrap before the clamp
   localparam int NumServo = 5;    // left, right, rudder, elevator, flap
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 60;
   localparam int EpW      = NumServo * ServoW;

   typedef enum logic [1:0] {
      FLAP_BASIC    = 2'd0,
      FLAP_PREMIXED = 2'd1,
      FLAP_ADVANCED = 2'd2,
      FLAP_HOLD     = 2'd3
   } flap_mode_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_FLAP_MODE     = 3'd0,
      CSR_FLAP_SPEED    = 3'd1,
      CSR_FLAP_STEP     = 3'd2,
      CSR_SERVO_MID     = 3'd3,
      CSR_REVERSE_MASK  = 3'd4,
      CSR_CHANNEL_FLAGS = 3'd5,
      CSR_ENDPOINT_LOW  = 3'd6,
      CSR_ENDPOINT_HIGH = 3'd7
   } csr_index_type;

   // bit positions in reverse_mask and channel_flags
   localparam int RevFlapBit  = 5;
   localparam int ChanFlapBit = 0;
   localparam int ChanAil2Bit = 1;

   typedef struct packed {
      flap_mode_type    mode;
      logic [7:0]       speed;
      logic [7:0]       step;
      logic [11:0]      mid;
      logic [5:0]       reverse;
      logic [1:0]       chan;
      logic [EpW-1:0]   ep_low;
      logic [EpW-1:0]   ep_high;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      mode:    FLAP_BASIC,
      speed:   8'd0,
      step:    8'd1,
      mid:     12'd1500,
      reverse: 6'd0,
      chan:    2'd0,
      ep_low:  {EpW{1'b0}},
      ep_high: {EpW{1'b1}}
   };

   typedef struct packed {
      logic signed [CmdW-1:0]  held_left;
      logic signed [CmdW-1:0]  held_right;
      logic signed [CmdW-1:0]  held_flap;
      logic signed [FlapW-1:0] slow_flap;
      logic [7:0]              skip_count;
   } state_type;

endpackage

`default_nettype wire

### rtl/afm_mix.sv
// afm_mix: combinational datapath for one control tick
// source select, flap slew, mixing, reverse and endpoint clamp; depends on afm_pkg
`default_nettype none

module afm_mix
   import afm_pkg::*;
(
   input  cfg_type                 cfg,
   input  state_type               st,
   input  logic signed [CmdW-1:0]  roll_cmd,
   input  logic signed [CmdW-1:0]  aileron2_cmd,
   input  logic signed [CmdW-1:0]  flap_cmd,
   input  logic signed [CmdW-1:0]  yaw_cmd,
   input  logic signed [CmdW-1:0]  pitch_cmd,
   input  logic signed [PidW-1:0]  pid_roll,
   input  logic signed [PidW-1:0]  pid_yaw,
   input  logic signed [PidW-1:0]  pid_pitch,
   input  logic                    passthrough,
   output state_type               st_next,
   output logic [NumServo-1:0][ServoW-1:0] servo
);

   function automatic logic [ServoW-1:0] clamp_servo(input logic signed [MixW-1:0] v,
                                                     input logic [ServoW-1:0] lo,
                                                     input logic [ServoW-1:0] hi);
      logic signed [MixW-1:0] lo_s;
      logic signed [MixW-1:0] hi_s;
      logic signed [MixW-1:0] r;
      lo_s = signed'(MixW'(lo));
      hi_s = signed'(MixW'(hi));
      if (v < lo_s) begin
         r = lo_s;
      end else if (v > hi_s) begin
         r = hi_s;
      end else begin
         r = v;
      end
      return r[ServoW-1:0];
   endfunction

   logic signed [FlapW-1:0] target;
   logic signed [FlapW-1:0] err;
   logic signed [FlapW-1:0] err_abs;
   logic signed [FlapW-1:0] step_sz;
   logic [7:0]              skip_inc;
   logic signed [MixW-1:0]  flaps;
   logic signed [MixW-1:0]  p_roll;
   logic signed [MixW-1:0]  p_yaw;
   logic signed [MixW-1:0]  p_pitch;
   logic signed [MixW-1:0]  sv [NumServo];
   logic signed [MixW-1:0]  v;

   always_comb begin
      st_next = st;

      // source selection, hold mode keeps the previous sources
      case (cfg.mode)
         FLAP_BASIC: begin
            st_next.held_left  = roll_cmd;
            st_next.held_right = roll_cmd;
            st_next.held_flap  = cfg.chan[ChanFlapBit] ? flap_cmd : '0;
         end
         FLAP_PREMIXED: begin
            st_next.held_left  = roll_cmd;
            st_next.held_right = cfg.chan[ChanAil2Bit] ? aileron2_cmd : roll_cmd;
            st_next.held_flap  = cfg.chan[ChanAil2Bit] ? flap_cmd : '0;
         end
         FLAP_ADVANCED: begin
            st_next.held_left  = roll_cmd;
            st_next.held_right = cfg.chan[ChanAil2Bit] ? aileron2_cmd : roll_cmd;
            st_next.held_flap  = cfg.chan[ChanFlapBit] ? flap_cmd : '0;
         end
         default: begin
         end
      endcase

      // flap slew toward the selected flap source
      target  = FlapW'(st_next.held_flap);
      err     = st.slow_flap - target;
      err_abs = (err < 0) ? -err : err;
      step_sz = (err_abs >= signed'(FlapW'(cfg.step))) ? signed'(FlapW'(cfg.step))
                                                       : signed'(FlapW'(1));
      if (cfg.speed != 8'd0) begin
         if (st.skip_count == cfg.speed) begin
            if (st.slow_flap < target) begin
               st_next.slow_flap = st.slow_flap + step_sz;
            end else if (st.slow_flap > target) begin
               st_next.slow_flap = st.slow_flap - step_sz;
            end
         end
      end else begin
         st_next.slow_flap = target;
      end
      skip_inc           = st.skip_count + 8'd1;
      st_next.skip_count = (skip_inc > cfg.speed) ? 8'd0 : skip_inc;

      // mixing at full width
      flaps   = cfg.reverse[RevFlapBit] ? -MixW'(st_next.slow_flap)
                                        : MixW'(st_next.slow_flap);
      p_roll  = passthrough ? '0 : MixW'(pid_roll);
      p_yaw   = passthrough ? '0 : MixW'(pid_yaw);
      p_pitch = passthrough ? '0 : MixW'(pid_pitch);
      sv[0]   = MixW'(st_next.held_left) + flaps - p_roll;
      sv[1]   = MixW'(st_next.held_right) - flaps - p_roll;
      sv[2]   = MixW'(yaw_cmd) - p_yaw;
      sv[3]   = MixW'(pitch_cmd) + p_pitch;
      sv[4]   = flaps;

      for (int k = 0; k < NumServo; k++) begin
         v = cfg.reverse[k] ? -sv[k] : sv[k];
         v = v + signed'(MixW'(cfg.mid));
         servo[k] = clamp_servo(v, cfg.ep_low[k*ServoW +: ServoW],
                                cfg.ep_high[k*ServoW +: ServoW]);
      end
   end

endmodule

`default_nettype wire

### rtl/airplane_flaperon_mixer_core.sv
// airplane_flaperon_mixer_core: top level of the flaperon mixer
// input register, afm_mix datapath, result register and csr file; depends on afm_pkg
`default_nettype none

// how to use it
//  - req channel: one control tick per transfer (throttle, stick commands, pid terms,
//    passthrough). req_ready stays high whenever the input register is empty or can move
//    into the result register, so ticks may come in every cycle.
//  - rsp channel: one result per tick, in order: throttle_out plus the five clamped servo
//    pulses left, right, rudder, elevator and flap.
//  - the req transfer loads the input register and the tick moves on into the result register
//    when that is empty or being read, which raises rsp_valid; unless the receiver stalls,
//    throughput is one tick per cycle, set by the single pass through afm_mix.
//  - csr channel: csr_ready is always high, a write lands at the edge of its transfer.
//    Write registers only while no tick is in flight.
//  - reset (synchronous, active high) loads the register defaults, clears the slew and
//    source state to zero and empties both pipeline registers.
//  - when the receiver stalls, the result register holds its value, the input register
//    holds one more tick and then req_ready drops until the stall clears.
//  - slew and held source state advance when a tick moves into the result register, so
//    they follow transfer order exactly.

module airplane_flaperon_mixer_core
   import afm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // input ticks
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ServoW-1:0]          req_throttle_in,
   input  logic signed [CmdW-1:0]     req_roll_cmd,
   input  logic signed [CmdW-1:0]     req_aileron2_cmd,
   input  logic signed [CmdW-1:0]     req_flap_cmd,
   input  logic signed [CmdW-1:0]     req_yaw_cmd,
   input  logic signed [CmdW-1:0]     req_pitch_cmd,
   input  logic signed [PidW-1:0]     req_pid_roll,
   input  logic signed [PidW-1:0]     req_pid_yaw,
   input  logic signed [PidW-1:0]     req_pid_pitch,
   input  logic                       req_passthrough,
   // results
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ServoW-1:0]          rsp_throttle_out,
   output logic [ServoW-1:0]          rsp_left_flaperon,
   output logic [ServoW-1:0]          rsp_right_flaperon,
   output logic [ServoW-1:0]          rsp_rudder,
   output logic [ServoW-1:0]          rsp_elevator,
   output logic [ServoW-1:0]          rsp_flap_servo,
   // register writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CsrIdxW-1:0]         csr_index,
   input  logic [CsrDataW-1:0]        csr_wdata
);

   cfg_type   cfg_ff;
   state_type st_ff;
   state_type st_in;

   // input register
   logic                    s1_valid_ff;
   logic [ServoW-1:0]       s1_throttle_ff;
   logic signed [CmdW-1:0]  s1_roll_ff;
   logic signed [CmdW-1:0]  s1_ail2_ff;
   logic signed [CmdW-1:0]  s1_flap_ff;
   logic signed [CmdW-1:0]  s1_yaw_ff;
   logic signed [CmdW-1:0]  s1_pitch_ff;
   logic signed [PidW-1:0]  s1_pid_roll_ff;
   logic signed [PidW-1:0]  s1_pid_yaw_ff;
   logic signed [PidW-1:0]  s1_pid_pitch_ff;
   logic                    s1_pass_ff;

   // result register
   logic                               rsp_valid_ff;
   logic [ServoW-1:0]                  rsp_throttle_ff;
   logic [NumServo-1:0][ServoW-1:0]    rsp_servo_ff;
   logic [NumServo-1:0][ServoW-1:0]    servo_in;

   logic req_xfer;
   logic out_load;

   // result register loads a waiting tick when it is empty or its contents leave this cycle
   assign out_load  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || out_load;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_FLAP_MODE:     cfg_ff.mode    <= flap_mode_type'(csr_wdata[1:0]);
            CSR_FLAP_SPEED:    cfg_ff.speed   <= csr_wdata[7:0];
            CSR_FLAP_STEP:     cfg_ff.step    <= csr_wdata[7:0];
            CSR_SERVO_MID:     cfg_ff.mid     <= csr_wdata[11:0];
            CSR_REVERSE_MASK:  cfg_ff.reverse <= csr_wdata[5:0];
            CSR_CHANNEL_FLAGS: cfg_ff.chan    <= csr_wdata[1:0];
            CSR_ENDPOINT_LOW:  cfg_ff.ep_low  <= csr_wdata[EpW-1:0];
            CSR_ENDPOINT_HIGH: cfg_ff.ep_high <= csr_wdata[EpW-1:0];
            default: begin
            end
         endcase
      end
   end

   // input register control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_throttle_ff  <= req_throttle_in;
         s1_roll_ff      <= req_roll_cmd;
         s1_ail2_ff      <= req_aileron2_cmd;
         s1_flap_ff      <= req_flap_cmd;
         s1_yaw_ff       <= req_yaw_cmd;
         s1_pitch_ff     <= req_pitch_cmd;
         s1_pid_roll_ff  <= req_pid_roll;
         s1_pid_yaw_ff   <= req_pid_yaw;
         s1_pid_pitch_ff <= req_pid_pitch;
         s1_pass_ff      <= req_passthrough;
      end
   end

   afm_mix u_mix (
      .cfg          (cfg_ff),
      .st           (st_ff),
      .roll_cmd     (s1_roll_ff),
      .aileron2_cmd (s1_ail2_ff),
      .flap_cmd     (s1_flap_ff),
      .yaw_cmd      (s1_yaw_ff),
      .pitch_cmd    (s1_pitch_ff),
      .pid_roll     (s1_pid_roll_ff),
      .pid_yaw      (s1_pid_yaw_ff),
      .pid_pitch    (s1_pid_pitch_ff),
      .passthrough  (s1_pass_ff),
      .st_next      (st_in),
      .servo        (servo_in)
   );

   // slew and held sources advance once per tick, as it enters the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (out_load) begin
         st_ff <= st_in;
      end
   end

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_throttle_ff <= s1_throttle_ff;
         rsp_servo_ff    <= servo_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_throttle_out   = rsp_throttle_ff;
   assign rsp_left_flaperon  = rsp_servo_ff[0];
   assign rsp_right_flaperon = rsp_servo_ff[1];
   assign rsp_rudder         = rsp_servo_ff[2];
   assign rsp_elevator       = rsp_servo_ff[3];
   assign rsp_flap_servo     = rsp_servo_ff[4];

endmodule

`default_nettype wire

### rtl/afm_checker.sv
// afm_checker: port-level assertions for airplane_flaperon_mixer_core
// bound to the top level below; depends on afm_pkg
`default_nettype none

module afm_checker
   import afm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [ServoW-1:0] rsp_throttle_out,
   input  logic [ServoW-1:0] rsp_left_flaperon,
   input  logic [ServoW-1:0] rsp_right_flaperon,
   input  logic [ServoW-1:0] rsp_rudder,
   input  logic [ServoW-1:0] rsp_elevator,
   input  logic [ServoW-1:0] rsp_flap_servo,
   input  logic              csr_ready
);

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // with nothing waiting at the output, a new tick is always taken
   a_ready_when_empty: assert property (@(posedge clock) !rsp_valid |-> req_ready)
      else $error("req_ready low while output empty");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_throttle_out)
         && $stable(rsp_left_flaperon) && $stable(rsp_right_flaperon)
         && $stable(rsp_rudder) && $stable(rsp_elevator) && $stable(rsp_flap_servo))
      else $error("stalled result changed");

   // register writes never stall, whatever the pipeline holds
   a_csr_ready: assert property (@(posedge clock) req_valid || !req_valid |-> csr_ready)
      else $error("csr_ready dropped");

endmodule

bind airplane_flaperon_mixer_core afm_checker u_afm_checker (.*);

`default_nettype wire

### tb/airplane_flaperon_mixer_core_tb.sv
// airplane_flaperon_mixer_core_tb: self-checking testbench for the flaperon mixer core
// predicts every result from its own copy of the mixer state and registers; depends on afm_pkg

module airplane_flaperon_mixer_core_tb;
   import afm_pkg::*;

   // one control tick as driven on the req channel
   typedef struct packed {
      logic [ServoW-1:0]      throttle;
      logic signed [CmdW-1:0] roll;
      logic signed [CmdW-1:0] ail2;
      logic signed [CmdW-1:0] flap;
      logic signed [CmdW-1:0] yaw;
      logic signed [CmdW-1:0] pitch;
      logic signed [PidW-1:0] pid_roll;
      logic signed [PidW-1:0] pid_yaw;
      logic signed [PidW-1:0] pid_pitch;
      logic                   passthrough;
   } tick_type;

   // one result: throttle plus servos left, right, rudder, elevator, flap
   typedef struct packed {
      logic [ServoW-1:0]                 throttle;
      logic [NumServo-1:0][ServoW-1:0]   servo;
   } pulses_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // req channel, every input starts at a known value
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [ServoW-1:0]      req_throttle_in = '0;
   logic signed [CmdW-1:0] req_roll_cmd = '0;
   logic signed [CmdW-1:0] req_aileron2_cmd = '0;
   logic signed [CmdW-1:0] req_flap_cmd = '0;
   logic signed [CmdW-1:0] req_yaw_cmd = '0;
   logic signed [CmdW-1:0] req_pitch_cmd = '0;
   logic signed [PidW-1:0] req_pid_roll = '0;
   logic signed [PidW-1:0] req_pid_yaw = '0;
   logic signed [PidW-1:0] req_pid_pitch = '0;
   logic                   req_passthrough = 1'b0;

   // rsp channel
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [ServoW-1:0] rsp_throttle_out;
   logic [ServoW-1:0] rsp_left_flaperon;
   logic [ServoW-1:0] rsp_right_flaperon;
   logic [ServoW-1:0] rsp_rudder;
   logic [ServoW-1:0] rsp_elevator;
   logic [ServoW-1:0] rsp_flap_servo;

   // register write channel
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   // shadow copy of the register file, loaded with the reset defaults
   flap_mode_type  cfg_mode = FLAP_BASIC;
   int             cfg_speed = 0;
   int             cfg_step = 1;
   int             cfg_mid = 1500;
   logic [5:0]     cfg_reverse = '0;
   logic [1:0]     cfg_chan = '0;
   logic [EpW-1:0] cfg_ep_low = '0;
   logic [EpW-1:0] cfg_ep_high = {EpW{1'b1}};

   // shadow copy of the slew and source state, all zero after reset
   int held_left = 0;
   int held_right = 0;
   int held_flap = 0;
   int slow_flap = 0;
   int skip_count = 0;

   // results still owed by the block, oldest first
   pulses_type expected_pulses [$];

   // bookkeeping
   int ticks_sent = 0;
   int results_checked = 0;
   int csr_writes = 0;
   int slew_moves = 0;
   int error_count = 0;
   int last_flap_cmd = 0;

   // idling control: quiet turns random idling off on both sides,
   // hold_request asks the receiver for a long stall that it counts itself
   bit quiet = 1'b0;
   int hold_request = 0;
   int hold_remaining = 0;

   string servo_names [NumServo] = '{"left_flaperon", "right_flaperon", "rudder",
                                     "elevator", "flap_servo"};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   airplane_flaperon_mixer_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_throttle_in    (req_throttle_in),
      .req_roll_cmd       (req_roll_cmd),
      .req_aileron2_cmd   (req_aileron2_cmd),
      .req_flap_cmd       (req_flap_cmd),
      .req_yaw_cmd        (req_yaw_cmd),
      .req_pitch_cmd      (req_pitch_cmd),
      .req_pid_roll       (req_pid_roll),
      .req_pid_yaw        (req_pid_yaw),
      .req_pid_pitch      (req_pid_pitch),
      .req_passthrough    (req_passthrough),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_throttle_out   (rsp_throttle_out),
      .rsp_left_flaperon  (rsp_left_flaperon),
      .rsp_right_flaperon (rsp_right_flaperon),
      .rsp_rudder         (rsp_rudder),
      .rsp_elevator       (rsp_elevator),
      .rsp_flap_servo     (rsp_flap_servo),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // ------------------------------------------------------------------
   // mixer prediction: advances the shadow state by one tick and returns
   // the six pulses the block has to produce for it
   // ------------------------------------------------------------------
   function automatic pulses_type compute_servo_pulses(input tick_type t);
      pulses_type p;
      int mix [NumServo];
      int flaps;
      int err_abs;
      int stride;
      int lo;
      int hi;
      int v;
      logic has_flap;
      logic has_ail2;
      has_flap = cfg_chan[ChanFlapBit];
      has_ail2 = cfg_chan[ChanAil2Bit];

      // source selection; hold mode keeps whatever was picked last
      case (cfg_mode)
         FLAP_BASIC: begin
            held_left  = int'(t.roll);
            held_right = int'(t.roll);
            held_flap  = has_flap ? int'(t.flap) : 0;
         end
         FLAP_PREMIXED: begin
            held_left  = int'(t.roll);
            held_right = has_ail2 ? int'(t.ail2) : int'(t.roll);
            // premixed takes the flap from the second aileron flag
            held_flap  = has_ail2 ? int'(t.flap) : 0;
         end
         FLAP_ADVANCED: begin
            held_left  = int'(t.roll);
            held_right = has_ail2 ? int'(t.ail2) : int'(t.roll);
            held_flap  = has_flap ? int'(t.flap) : 0;
         end
         default: ;
      endcase

      // flap slew: coarse step while far off, unit step when close, and with a nonzero speed
      // only on the tick where the counter reaches it; speed zero follows the target at once
      if (cfg_speed != 0) begin
         err_abs = slow_flap - held_flap;
         if (err_abs < 0) err_abs = -err_abs;
         stride = (err_abs >= cfg_step) ? cfg_step : 1;
         if (skip_count == cfg_speed && slow_flap != held_flap) begin
            slow_flap += (slow_flap < held_flap) ? stride : -stride;
            if (stride != 0) slew_moves++;
         end
      end else begin
         slow_flap = held_flap;
      end
      skip_count = (skip_count + 1) % 256;
      if (skip_count > cfg_speed) skip_count = 0;

      flaps = cfg_reverse[RevFlapBit] ? -slow_flap : slow_flap;

      // wide mix, no wrap anywhere before the clamp
      mix[0] = held_left + flaps;
      mix[1] = held_right - flaps;
      mix[2] = int'(t.yaw);
      mix[3] = int'(t.pitch);
      mix[4] = flaps;
      if (!t.passthrough) begin
         mix[0] -= int'(t.pid_roll);
         mix[1] -= int'(t.pid_roll);
         mix[2] -= int'(t.pid_yaw);
         mix[3] += int'(t.pid_pitch);
      end

      p.throttle = t.throttle;
      for (int k = 0; k < NumServo; k++) begin
         lo = int'(cfg_ep_low[ServoW*k +: ServoW]);
         hi = int'(cfg_ep_high[ServoW*k +: ServoW]);
         v = cfg_reverse[k] ? -mix[k] : mix[k];
         v += cfg_mid;
         // inverted endpoints: the low endpoint below it, the high endpoint otherwise
         if (v < lo) v = lo;
         else if (v > hi) v = hi;
         p.servo[k] = v[ServoW-1:0];
      end
      return p;
   endfunction

   // ------------------------------------------------------------------
   // result side: random stalls, an optional long hold, and the checker
   // ------------------------------------------------------------------
   task automatic compare_field(input string what, input logic [ServoW-1:0] want,
                                input logic [ServoW-1:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= 10)
            $display("mismatch on %s in result %0d: expected %0d, got %0d",
                     what, results_checked, want, got);
      end
   endtask

   task automatic check_pulses();
      pulses_type want;
      if (expected_pulses.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("result transfer with nothing outstanding (throttle %0d)",
                     rsp_throttle_out);
      end else begin
         want = expected_pulses.pop_front();
         compare_field("throttle_out", want.throttle, rsp_throttle_out);
         compare_field(servo_names[0], want.servo[0], rsp_left_flaperon);
         compare_field(servo_names[1], want.servo[1], rsp_right_flaperon);
         compare_field(servo_names[2], want.servo[2], rsp_rudder);
         compare_field(servo_names[3], want.servo[3], rsp_elevator);
         compare_field(servo_names[4], want.servo[4], rsp_flap_servo);
         results_checked++;
      end
   endtask

   // sample the transfer with pre-edge values, then pick next cycle's ready
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) check_pulses();
      if (hold_remaining == 0 && hold_request != 0) begin
         hold_remaining = hold_request;
         hold_request = 0;
      end
      if (hold_remaining != 0) begin
         hold_remaining--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(0, 99) >= 7);
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers; every task is entered and left right after a rising edge
   // ------------------------------------------------------------------
   function automatic int pick_in_range(input int lo, input int hi);
      case ($urandom_range(0, 9))
         0: return lo;
         1: return hi;
         default: return lo + int'($urandom_range(0, hi - lo));
      endcase
   endfunction

   function automatic tick_type make_tick(input int thr, input int roll, input int ail2,
                                          input int flap, input int yaw, input int pitch,
                                          input int pr, input int py, input int pp,
                                          input bit pass);
      tick_type t;
      t.throttle    = ServoW'(thr);
      t.roll        = CmdW'(roll);
      t.ail2        = CmdW'(ail2);
      t.flap        = CmdW'(flap);
      t.yaw         = CmdW'(yaw);
      t.pitch       = CmdW'(pitch);
      t.pid_roll    = PidW'(pr);
      t.pid_yaw     = PidW'(py);
      t.pid_pitch   = PidW'(pp);
      t.passthrough = pass;
      return t;
   endfunction

   // flap command sticks for runs of ticks so the slew has a target to chase
   function automatic tick_type random_tick();
      if ($urandom_range(0, 4) == 0) last_flap_cmd = pick_in_range(-2048, 2047);
      return make_tick(pick_in_range(0, 4095), pick_in_range(-2048, 2047),
                       pick_in_range(-2048, 2047), last_flap_cmd,
                       pick_in_range(-2048, 2047), pick_in_range(-2048, 2047),
                       pick_in_range(-4096, 4095), pick_in_range(-4096, 4095),
                       pick_in_range(-4096, 4095), 1'($urandom_range(0, 1)));
   endfunction

   function automatic logic [EpW-1:0] random_ends(input int lo, input int hi);
      logic [EpW-1:0] ends;
      for (int k = 0; k < NumServo; k++)
         ends[ServoW*k +: ServoW] = ServoW'(pick_in_range(lo, hi));
      return ends;
   endfunction

   // one tick on the req channel; valid is only touched once per edge
   task automatic send_tick(input tick_type t);
      if (!quiet) begin
         while ($urandom_range(0, 99) < 7) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_throttle_in  <= t.throttle;
      req_roll_cmd     <= t.roll;
      req_aileron2_cmd <= t.ail2;
      req_flap_cmd     <= t.flap;
      req_yaw_cmd      <= t.yaw;
      req_pitch_cmd    <= t.pitch;
      req_pid_roll     <= t.pid_roll;
      req_pid_yaw      <= t.pid_yaw;
      req_pid_pitch    <= t.pid_pitch;
      req_passthrough  <= t.passthrough;
      do @(posedge clock); while (!req_ready);
      expected_pulses.push_back(compute_servo_pulses(t));
      ticks_sent++;
   endtask

   // stop offering ticks and wait until every result is back
   task automatic drain_pipe();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_pulses.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CsrDataW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FLAP_MODE:     cfg_mode    = flap_mode_type'(data[1:0]);
         CSR_FLAP_SPEED:    cfg_speed   = int'(data[7:0]);
         CSR_FLAP_STEP:     cfg_step    = int'(data[7:0]);
         CSR_SERVO_MID:     cfg_mid     = int'(data[11:0]);
         CSR_REVERSE_MASK:  cfg_reverse = data[5:0];
         CSR_CHANNEL_FLAGS: cfg_chan    = data[1:0];
         CSR_ENDPOINT_LOW:  cfg_ep_low  = data[EpW-1:0];
         CSR_ENDPOINT_HIGH: cfg_ep_high = data[EpW-1:0];
         default: ;
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // full register set; only called with the pipe drained
   task automatic load_settings(input flap_mode_type mode, input int speed, input int step,
                                input int mid, input int rev, input int chan,
                                input logic [EpW-1:0] ep_low, input logic [EpW-1:0] ep_high);
      write_csr(CSR_FLAP_MODE, CsrDataW'(mode));
      write_csr(CSR_FLAP_SPEED, CsrDataW'(speed));
      write_csr(CSR_FLAP_STEP, CsrDataW'(step));
      write_csr(CSR_SERVO_MID, CsrDataW'(mid));
      write_csr(CSR_REVERSE_MASK, CsrDataW'(rev));
      write_csr(CSR_CHANNEL_FLAGS, CsrDataW'(chan));
      write_csr(CSR_ENDPOINT_LOW, CsrDataW'(ep_low));
      write_csr(CSR_ENDPOINT_HIGH, CsrDataW'(ep_high));
   endtask

   task automatic random_settings();
      int speed;
      int step;
      logic [EpW-1:0] ep_low;
      logic [EpW-1:0] ep_high;
      case ($urandom_range(0, 7))
         0, 1: speed = 0;
         2:    speed = 255;
         default: speed = $urandom_range(1, 4);
      endcase
      step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
      // mostly sane endpoint windows, now and then raw bits including inverted pairs
      if ($urandom_range(0, 3) == 0) begin
         ep_low  = EpW'({$urandom, $urandom});
         ep_high = EpW'({$urandom, $urandom});
      end else begin
         ep_low  = random_ends(0, 1800);
         ep_high = random_ends(1200, 4095);
      end
      load_settings(flap_mode_type'($urandom_range(0, 3)), speed, step,
                    $urandom_range(0, 4095), $urandom_range(0, 63), $urandom_range(0, 3),
                    ep_low, ep_high);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // nothing written yet: the reset defaults of every register are in play
   task automatic test_reset_values();
      send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
      send_tick(make_tick(4095, 2047, 2047, 2047, 2047, 2047, 4095, 4095, 4095, 1'b0));
      send_tick(make_tick(1234, -2048, -2048, -2048, -2048, -2048, -4096, -4096, -4096,
                          1'b1));
      drain_pipe();
   endtask

   // field extremes with a centered midpoint so both rails are reached
   task automatic test_field_extremes();
      load_settings(FLAP_ADVANCED, 0, 1, 2048, 0, 3, '0, {EpW{1'b1}});
      send_tick(make_tick(4095, 2047, -2048, 2047, -2048, 2047, -4096, 4095, -4096, 1'b0));
      send_tick(make_tick(0, -2048, 2047, -2048, 2047, -2048, 4095, -4096, 4095, 1'b0));
      send_tick(make_tick(4095, 2047, -2048, 2047, -2048, 2047, -4096, 4095, -4096, 1'b1));
      send_tick(make_tick(2048, -1, 1, -1, 1, -1, -1, 1, -1, 1'b0));
      drain_pipe();
   endtask

   // every flap mode, with the channel flags that change each source pick
   task automatic test_flap_modes();
      load_settings(FLAP_BASIC, 0, 1, 1500, 0, 1, '0, {EpW{1'b1}});
      send_tick(random_tick());
      drain_pipe();
      load_settings(FLAP_PREMIXED, 0, 1, 1500, 0, 2, '0, {EpW{1'b1}});
      send_tick(random_tick());
      drain_pipe();
      // premixed without the second aileron: no flap even with the flap channel present
      load_settings(FLAP_PREMIXED, 0, 1, 1500, 0, 1, '0, {EpW{1'b1}});
      send_tick(make_tick(100, 300, -700, 900, 0, 0, 0, 0, 0, 1'b1));
      drain_pipe();
      load_settings(FLAP_ADVANCED, 0, 1, 1500, 0, 2, '0, {EpW{1'b1}});
      send_tick(random_tick());
      drain_pipe();
      // hold mode: sources stay as the advanced tick left them
      load_settings(FLAP_HOLD, 0, 1, 1500, 0, 3, '0, {EpW{1'b1}});
      send_tick(make_tick(500, -2048, 2047, -2048, 10, 20, 30, 40, 50, 1'b0));
      send_tick(random_tick());
      drain_pipe();
   endtask

   // slew toward a far target, then a zero step and the slowest speed
   task automatic test_flap_slew();
      load_settings(FLAP_BASIC, 1, 200, 1500, 0, 1, '0, {EpW{1'b1}});
      repeat (6) send_tick(make_tick(1000, 0, 0, 2047, 0, 0, 0, 0, 0, 1'b1));
      drain_pipe();
      // zero step with the flap contribution reversed: slow flap stands still
      load_settings(FLAP_BASIC, 1, 0, 1500, 'h20, 1, '0, {EpW{1'b1}});
      repeat (2) send_tick(make_tick(1000, 0, 0, -2048, 0, 0, 0, 0, 0, 1'b1));
      drain_pipe();
      load_settings(FLAP_BASIC, 255, 255, 1500, 0, 1, '0, {EpW{1'b1}});
      repeat (2) send_tick(make_tick(1000, 0, 0, -2048, 0, 0, 0, 0, 0, 1'b0));
      drain_pipe();
   endtask

   // every servo reversed, inverted endpoints, midpoint at both ends
   task automatic test_endpoint_limits();
      load_settings(FLAP_ADVANCED, 0, 1, 0, 63, 3, {NumServo{12'd3000}},
                    {NumServo{12'd1000}});
      send_tick(random_tick());
      send_tick(random_tick());
      drain_pipe();
      load_settings(FLAP_BASIC, 0, 255, 4095, 0, 0, '0, '0);
      send_tick(random_tick());
      drain_pipe();
      load_settings(FLAP_PREMIXED, 3, 1, 4095, 'h15, 2, random_ends(0, 4095),
                    {NumServo{12'hfff}});
      send_tick(random_tick());
      drain_pipe();
   endtask

   // random ticks under a series of random settings; the first phase runs with no idling
   task automatic test_random_settings();
      for (int phase = 0; phase < 8; phase++) begin
         random_settings();
         quiet = (phase == 0);
         repeat (50) send_tick(random_tick());
         drain_pipe();
      end
      quiet = 1'b0;
   endtask

   // receiver holds off long enough that the block fills and drops req_ready
   task automatic test_backpressure();
      load_settings(FLAP_ADVANCED, 2, 8, 1500, $urandom_range(0, 63), 3,
                    random_ends(0, 1500), random_ends(1500, 4095));
      hold_request = 60;
      repeat (30) send_tick(random_tick());
      drain_pipe();
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_field_extremes();
      test_flap_modes();
      test_flap_slew();
      test_endpoint_limits();
      test_random_settings();
      test_backpressure();

      // allow a stray extra result to show up before the verdict
      repeat (10) @(posedge clock);

      $display("covered %0d ticks and %0d results over %0d register writes",
               ticks_sent, results_checked, csr_writes);
      $display("flap modes, slew (%0d moves), reversal, clamps and a long result stall",
               slew_moves);
      if (error_count == 0) begin
         $display("airplane_flaperon_mixer_core_tb: done, clean");
      end else begin
         $display("%0d errors", error_count);
         $display("airplane_flaperon_mixer_core_tb: done, errors");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", expected_pulses.size());
      $display("airplane_flaperon_mixer_core_tb: done, errors");
      $finish;
   end

endmodule
